// ----- rtl/c2pe_pkg.sv -----
// shared constants, types and helpers for the convolution point evaluator
`timescale 1ns / 1ps

package c2pe_pkg;

	// store geometry
	localparam int MAX_DIM      = 32;
	localparam int MAX_CHANNELS = 4;
	localparam int MAX_FILTERS  = 8;
	localparam int MAX_KERNEL   = 5;

	localparam int PIX_DEPTH = MAX_CHANNELS * MAX_DIM * MAX_DIM;
	localparam int WGT_DEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
	localparam int PIX_AW    = $clog2(PIX_DEPTH);
	localparam int WGT_AW    = $clog2(WGT_DEPTH);
	localparam int DIM_W     = $clog2(MAX_DIM);
	localparam int CH_W      = $clog2(MAX_CHANNELS);
	localparam int FLT_W     = $clog2(MAX_FILTERS);
	localparam int KER_W     = $clog2(MAX_KERNEL);

	// field widths
	localparam int PIX_W  = 16;
	localparam int BIAS_W = 32;
	localparam int LOAD_W = 32;
	localparam int PROD_W = 2 * PIX_W;
	localparam int OUT_W  = 48;
	localparam int ACC_W  = OUT_W + 1;
	localparam int CFG_W  = 6;

	// status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_RANGE = 1'b1;

	// opcodes
	typedef enum logic [1:0] {
		OP_PIXEL  = 2'd0,
		OP_WEIGHT = 2'd1,
		OP_BIAS   = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_IN_HEIGHT  = 3'd0,
		REG_IN_WIDTH   = 3'd1,
		REG_CHANNELS   = 3'd2,
		REG_FILTERS    = 3'd3,
		REG_K_HEIGHT   = 3'd4,
		REG_K_WIDTH    = 3'd5,
		REG_STEP       = 3'd6,
		REG_PAD        = 3'd7
	} reg_idx_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SETUP = 2'd1,
		ST_RUN   = 2'd2,
		ST_DRAIN = 2'd3
	} state_t;

	// saturate a 32-bit load value to the signed 16-bit range
	function automatic logic signed [PIX_W-1:0] sat16(input logic signed [LOAD_W-1:0] v);
		logic signed [PIX_W-1:0] r;
		if (v > $signed(LOAD_W'(32'sd32767)))
			r = 16'sh7fff;
		else if (v < $signed(-32'sd32768))
			r = 16'sh8000;
		else
			r = v[PIX_W-1:0];
		return r;
	endfunction

	// clip the accumulator to the signed 48-bit range
	function automatic logic signed [OUT_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
		logic signed [OUT_W-1:0] r;
		if (v[ACC_W-1] != v[ACC_W-2])
			r = v[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
		else
			r = v[OUT_W-1:0];
		return r;
	endfunction

endpackage

// ----- rtl/c2pe_if.sv -----
// command and response channel interfaces
`timescale 1ns / 1ps

interface c2pe_cmd_if import c2pe_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               opcode;
	logic [2:0]               filter_index;
	logic [1:0]               channel_index;
	logic [4:0]               row_index;
	logic [4:0]               col_index;
	logic signed [LOAD_W-1:0] load_value;

	modport source(output valid, opcode, filter_index, channel_index, row_index, col_index,
		load_value, input ready);
	modport sink(input valid, opcode, filter_index, channel_index, row_index, col_index,
		load_value, output ready);
endinterface

interface c2pe_rsp_if import c2pe_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] conv_value;
	logic                    status;

	modport source(output valid, conv_value, status, input ready);
	modport sink(input valid, conv_value, status, output ready);
endinterface

// ----- rtl/c2pe_ram.sv -----
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps

module c2pe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/conv2d_point_evaluator.sv -----
// top level: convolution point evaluator with pixel, weight and bias stores
//
// usage
// - cmd channel (valid/ready): opcode selects load pixel, load weight, load bias
//   or query one output point; every transaction produces exactly one response
// - rsp channel (valid/ready): conv_value (Q32.16, saturated to 48 bits) and
//   status (1 = index outside the configured sizes, value then zero)
// - cfg port: cfg_we with cfg_index/cfg_data writes one size register per
//   cycle; write only while no command is outstanding
// - loads write their store on acceptance; the response is valid the next cycle
// - a query passes a setup state, an issue state that steps through every kernel
//   tap of every channel (one multiply-accumulate each through a single shared
//   multiplier) and a drain state that waits for the pipeline to empty; an
//   out-of-range query answers straight from the setup state
// - a new command is taken in the cycle its predecessor's response is taken, so
//   loads run one per cycle while rsp.ready is high; a query blocks until answered
// - cmd.ready is low while a query runs and while a finished response is held
//   and not taken; the response register holds its value until rsp.ready
// - reset (arst_n low) sets the size registers to 32,32,1,1,3,3,1,0 and
//   empties the response register; store contents stay undefined until loaded
`timescale 1ns / 1ps

module conv2d_point_evaluator import c2pe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	c2pe_cmd_if.sink          cmd,
	c2pe_rsp_if.source        rsp,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	// size registers
	logic [5:0] in_height_q, in_width_q;
	logic [2:0] channels_q;
	logic [3:0] filters_q;
	logic [2:0] k_height_q, k_width_q;
	logic [3:0] step_q;
	logic [2:0] pad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q <= 6'd32;
			in_width_q  <= 6'd32;
			channels_q  <= 3'd1;
			filters_q   <= 4'd1;
			k_height_q  <= 3'd3;
			k_width_q   <= 3'd3;
			step_q      <= 4'd1;
			pad_q       <= 3'd0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_IN_HEIGHT: in_height_q <= cfg_data[5:0];
				REG_IN_WIDTH:  in_width_q  <= cfg_data[5:0];
				REG_CHANNELS:  channels_q  <= cfg_data[2:0];
				REG_FILTERS:   filters_q   <= cfg_data[3:0];
				REG_K_HEIGHT:  k_height_q  <= cfg_data[2:0];
				REG_K_WIDTH:   k_width_q   <= cfg_data[2:0];
				REG_STEP:      step_q      <= cfg_data[3:0];
				REG_PAD:       pad_q       <= cfg_data[2:0];
				default:       ;
			endcase
		end
	end

	// effective sizes after clamping
	logic [5:0] ih, iw;
	logic [2:0] nc, kh, kw;
	logic [3:0] nf, st;

	always_comb begin
		ih = (in_height_q == '0) ? 6'd1 : (in_height_q > 6'(MAX_DIM)) ? 6'(MAX_DIM) : in_height_q;
		iw = (in_width_q == '0) ? 6'd1 : (in_width_q > 6'(MAX_DIM)) ? 6'(MAX_DIM) : in_width_q;
		nc = (channels_q == '0) ? 3'd1
			: (channels_q > 3'(MAX_CHANNELS)) ? 3'(MAX_CHANNELS) : channels_q;
		nf = (filters_q == '0) ? 4'd1
			: (filters_q > 4'(MAX_FILTERS)) ? 4'(MAX_FILTERS) : filters_q;
		kh = (k_height_q == '0) ? 3'd1
			: (k_height_q > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : k_height_q;
		kw = (k_width_q == '0) ? 3'd1
			: (k_width_q > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : k_width_q;
		st = (step_q == '0) ? 4'd1 : step_q;
	end

	// control and query registers
	state_t                   state_q, state_d;
	logic [FLT_W-1:0]         flt_q;
	logic [4:0]               row_q, col_q;
	logic signed [10:0]       base_r_q, base_c_q;
	logic [CH_W-1:0]          z_q;
	logic [KER_W-1:0]         a_q, b_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [BIAS_W-1:0]        bias_q [MAX_FILTERS];
	logic                     vld_s1, vld_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     out_valid_q;
	logic signed [OUT_W-1:0]  out_value_q;
	logic                     out_status_q;

	// handshake
	logic out_free, cmd_acc;
	assign out_free  = !out_valid_q || rsp.ready;
	assign cmd.ready = (state_q == ST_IDLE) && out_free;
	assign cmd_acc   = cmd.valid && cmd.ready;

	// load range checks on the incoming command
	logic pix_ok, wgt_ok, bias_ok;
	op_t  cmd_op;
	assign cmd_op  = op_t'(cmd.opcode);
	assign pix_ok  = (3'(cmd.channel_index) < nc) && (6'(cmd.row_index) < ih)
		&& (6'(cmd.col_index) < iw);
	assign wgt_ok  = (4'(cmd.filter_index) < nf) && (3'(cmd.channel_index) < nc)
		&& (3'(cmd.row_index) < kh) && (cmd.row_index < 5'(MAX_KERNEL))
		&& (3'(cmd.col_index) < kw) && (cmd.col_index < 5'(MAX_KERNEL));
	assign bias_ok = 4'(cmd.filter_index) < nf;

	// store write addresses and data
	logic              pix_we, wgt_we;
	logic [PIX_AW-1:0] pix_waddr;
	logic [WGT_AW-1:0] wgt_waddr;
	logic [PIX_W-1:0]  load_sat;

	assign load_sat  = sat16(cmd.load_value);
	assign pix_we    = cmd_acc && (cmd_op == OP_PIXEL) && pix_ok;
	assign wgt_we    = cmd_acc && (cmd_op == OP_WEIGHT) && wgt_ok;
	assign pix_waddr = PIX_AW'(cmd.channel_index) * PIX_AW'(MAX_DIM * MAX_DIM)
		+ PIX_AW'(cmd.row_index[DIM_W-1:0]) * PIX_AW'(MAX_DIM)
		+ PIX_AW'(cmd.col_index[DIM_W-1:0]);
	assign wgt_waddr = ((WGT_AW'(cmd.filter_index) * WGT_AW'(MAX_CHANNELS)
		+ WGT_AW'(cmd.channel_index)) * WGT_AW'(MAX_KERNEL)
		+ WGT_AW'(cmd.row_index)) * WGT_AW'(MAX_KERNEL) + WGT_AW'(cmd.col_index);

	// bias registers, written on acceptance
	always_ff @(posedge clk) begin
		if (cmd_acc && (cmd_op == OP_BIAS) && bias_ok) begin
			bias_q[cmd.filter_index] <= cmd.load_value;
		end
	end

	// query setup: output-size check without division (row*step <= span)
	logic signed [8:0] span_h, span_w;
	logic [8:0]        rs, cs;
	logic              query_ok;

	always_comb begin
		span_h   = $signed(9'(ih) + 9'({pad_q, 1'b0}) - 9'(kh));
		span_w   = $signed(9'(iw) + 9'({pad_q, 1'b0}) - 9'(kw));
		rs       = 9'(row_q) * 9'(st);
		cs       = 9'(col_q) * 9'(st);
		query_ok = (4'(flt_q) < nf) && !span_h[8] && !span_w[8]
			&& (rs <= 9'(span_h)) && (cs <= 9'(span_w));
	end

	// window position for the current kernel tap
	logic signed [10:0] pr, pc;
	logic               tap_in;
	logic [PIX_AW-1:0]  pix_raddr;
	logic [WGT_AW-1:0]  wgt_raddr;
	logic               last_b, last_a, last_z;

	always_comb begin
		pr        = base_r_q + $signed(11'(a_q));
		pc        = base_c_q + $signed(11'(b_q));
		tap_in    = !pr[10] && !pc[10] && ($unsigned(pr) < 11'(ih)) && ($unsigned(pc) < 11'(iw));
		pix_raddr = PIX_AW'(z_q) * PIX_AW'(MAX_DIM * MAX_DIM)
			+ PIX_AW'(pr[DIM_W-1:0]) * PIX_AW'(MAX_DIM) + PIX_AW'(pc[DIM_W-1:0]);
		wgt_raddr = ((WGT_AW'(flt_q) * WGT_AW'(MAX_CHANNELS) + WGT_AW'(z_q))
			* WGT_AW'(MAX_KERNEL) + WGT_AW'(a_q)) * WGT_AW'(MAX_KERNEL) + WGT_AW'(b_q);
		last_b    = b_q == KER_W'(kw - 3'd1);
		last_a    = a_q == KER_W'(kh - 3'd1);
		last_z    = z_q == CH_W'(nc - 3'd1);
	end

	// stores
	logic [PIX_W-1:0] pix_rdata, wgt_rdata;

	c2pe_ram #(.WIDTH(PIX_W), .DEPTH(PIX_DEPTH)) u_pix_ram (
		.clk   (clk),
		.we    (pix_we),
		.waddr (pix_waddr),
		.wdata (load_sat),
		.raddr (pix_raddr),
		.rdata (pix_rdata)
	);

	c2pe_ram #(.WIDTH(PIX_W), .DEPTH(WGT_DEPTH)) u_wgt_ram (
		.clk   (clk),
		.we    (wgt_we),
		.waddr (wgt_waddr),
		.wdata (load_sat),
		.raddr (wgt_raddr),
		.rdata (wgt_rdata)
	);

	// sequencer next state and response write
	logic                    issue, start_run, out_load, out_stat_d;
	logic signed [OUT_W-1:0] out_val_d;
	logic signed [ACC_W-1:0] final_sum;

	assign final_sum = acc_q + ACC_W'($signed(bias_q[flt_q]));

	always_comb begin
		state_d    = state_q;
		issue      = 1'b0;
		start_run  = 1'b0;
		out_load   = 1'b0;
		out_val_d  = '0;
		out_stat_d = STATUS_OK;
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					case (cmd_op)
						OP_PIXEL: begin
							out_load   = 1'b1;
							out_stat_d = pix_ok ? STATUS_OK : STATUS_RANGE;
						end
						OP_WEIGHT: begin
							out_load   = 1'b1;
							out_stat_d = wgt_ok ? STATUS_OK : STATUS_RANGE;
						end
						OP_BIAS: begin
							out_load   = 1'b1;
							out_stat_d = bias_ok ? STATUS_OK : STATUS_RANGE;
						end
						default: state_d = ST_SETUP;
					endcase
				end
			end
			ST_SETUP: begin
				if (query_ok) begin
					start_run = 1'b1;
					state_d   = ST_RUN;
				end else if (out_free) begin
					out_load   = 1'b1;
					out_stat_d = STATUS_RANGE;
					state_d    = ST_IDLE;
				end
			end
			ST_RUN: begin
				issue = 1'b1;
				if (last_b && last_a && last_z) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!vld_s1 && !vld_s2 && out_free) begin
					out_load  = 1'b1;
					out_val_d = sat48(final_sum);
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register and multiply-accumulate pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue && tap_in;
			vld_s2  <= vld_s1;
		end
	end

	// query operands, tap counters and accumulator
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			flt_q <= cmd.filter_index;
			row_q <= cmd.row_index;
			col_q <= cmd.col_index;
		end
		if (start_run) begin
			base_r_q <= $signed(11'(rs)) - $signed(11'(pad_q));
			base_c_q <= $signed(11'(cs)) - $signed(11'(pad_q));
			z_q      <= '0;
			a_q      <= '0;
			b_q      <= '0;
			acc_q    <= '0;
		end else begin
			if (issue) begin
				if (last_b) begin
					b_q <= '0;
					if (last_a) begin
						a_q <= '0;
						z_q <= z_q + CH_W'(1);
					end else begin
						a_q <= a_q + KER_W'(1);
					end
				end else begin
					b_q <= b_q + KER_W'(1);
				end
			end
			if (vld_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
		end
		prod_s2 <= $signed(pix_rdata) * $signed(wgt_rdata);
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q  <= out_val_d;
			out_status_q <= out_stat_d;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.conv_value = out_value_q;
	assign rsp.status     = out_status_q;

	// commands are taken only by an idle sequencer with room for the response
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> (state_q == ST_IDLE) && out_free)
		else $error("command taken while sequencer busy or response slot full");

	// a load answers in the next cycle with a zero value
	a_load_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && (cmd.opcode != OP_QUERY))
		|=> (rsp.valid && (rsp.conv_value == '0)))
		else $error("load transaction without immediate zero response");

	// no multiply-accumulate work is left when the sequencer is idle
	a_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!vld_s1 && !vld_s2))
		else $error("accumulate pipeline busy in idle state");

endmodule

// ----- bench/conv_point_checker.sv -----
// checker that predicts convolution point results and compares them with the responses
`timescale 1ns / 1ps

module conv_point_checker import c2pe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	c2pe_cmd_if              cmd,
	c2pe_rsp_if              rsp,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int               fail_count,
	output int               pending_count
);

	typedef struct packed {
		logic signed [OUT_W-1:0] value;
		logic                    status;
	} point_result_t;

	localparam longint OUT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
	localparam longint OUT_MIN = -(longint'(1) <<< (OUT_W - 1));

	// private copy of the stores and the size registers
	logic signed [PIX_W-1:0]  pixel_mem  [PIX_DEPTH];
	logic signed [PIX_W-1:0]  weight_mem [WGT_DEPTH];
	logic signed [BIAS_W-1:0] bias_mem   [MAX_FILTERS];
	logic [CFG_W-1:0]         size_reg   [8];
	point_result_t            expected_points [$];

	function automatic int reg_bits(input logic [2:0] idx);
		case (reg_idx_t'(idx))
			REG_IN_HEIGHT, REG_IN_WIDTH: return 6;
			REG_FILTERS, REG_STEP: return 4;
			default: return 3;
		endcase
	endfunction

	function automatic int clamp_size(input logic [CFG_W-1:0] v, input int hi);
		if (v == 0)
			return 1;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic int out_dim(input int in_dim, input int pad, input int kern, input int step);
		int span;
		span = in_dim + 2 * pad - kern;
		if (span < 0)
			return 0;
		return span / step + 1;
	endfunction

	function automatic logic signed [PIX_W-1:0] clip16(input logic signed [LOAD_W-1:0] v);
		if (v > 32767)
			return 16'sh7fff;
		if (v < -32768)
			return 16'sh8000;
		return v[PIX_W-1:0];
	endfunction

	// apply one command to the private state and work out its response
	function automatic point_result_t predict_point(input op_t op, input int f, input int ch,
		input int r, input int c, input logic signed [LOAD_W-1:0] lv);
		point_result_t res;
		int ih, iw, nc, nf, kh, kw, st, pd, pr, pc, z, a, b;
		longint acc;
		res.value  = '0;
		res.status = STATUS_OK;
		ih = clamp_size(size_reg[REG_IN_HEIGHT], MAX_DIM);
		iw = clamp_size(size_reg[REG_IN_WIDTH], MAX_DIM);
		nc = clamp_size(size_reg[REG_CHANNELS], MAX_CHANNELS);
		nf = clamp_size(size_reg[REG_FILTERS], MAX_FILTERS);
		kh = clamp_size(size_reg[REG_K_HEIGHT], MAX_KERNEL);
		kw = clamp_size(size_reg[REG_K_WIDTH], MAX_KERNEL);
		st = (size_reg[REG_STEP] == 0) ? 1 : int'(size_reg[REG_STEP]);
		pd = int'(size_reg[REG_PAD]);
		case (op)
			OP_PIXEL: begin
				if (ch < nc && r < ih && c < iw)
					pixel_mem[(ch * MAX_DIM + r) * MAX_DIM + c] = clip16(lv);
				else
					res.status = STATUS_RANGE;
			end
			OP_WEIGHT: begin
				if (f < nf && ch < nc && r < kh && c < kw)
					weight_mem[((f * MAX_CHANNELS + ch) * MAX_KERNEL + r) * MAX_KERNEL + c] =
						clip16(lv);
				else
					res.status = STATUS_RANGE;
			end
			OP_BIAS: begin
				if (f < nf)
					bias_mem[f] = lv;
				else
					res.status = STATUS_RANGE;
			end
			default: begin
				if (f < nf && r < out_dim(ih, pd, kh, st) && c < out_dim(iw, pd, kw, st)) begin
					acc = bias_mem[f];
					for (z = 0; z < nc; z++)
						for (a = 0; a < kh; a++)
							for (b = 0; b < kw; b++) begin
								pr = r * st + a - pd;
								pc = c * st + b - pd;
								// zero border contributes nothing
								if (pr >= 0 && pr < ih && pc >= 0 && pc < iw)
									acc += longint'(pixel_mem[(z * MAX_DIM + pr) * MAX_DIM + pc]) *
										longint'(weight_mem[((f * MAX_CHANNELS + z) * MAX_KERNEL + a)
										* MAX_KERNEL + b]);
							end
					if (acc > OUT_MAX)
						acc = OUT_MAX;
					if (acc < OUT_MIN)
						acc = OUT_MIN;
					res.value = acc[OUT_W-1:0];
				end else begin
					res.status = STATUS_RANGE;
				end
			end
		endcase
		return res;
	endfunction

	// register writes, response checks and command predictions
	always @(posedge clk or negedge arst_n) begin
		point_result_t want;
		if (!arst_n) begin
			size_reg[REG_IN_HEIGHT] = 6'd32;
			size_reg[REG_IN_WIDTH]  = 6'd32;
			size_reg[REG_CHANNELS]  = 6'd1;
			size_reg[REG_FILTERS]   = 6'd1;
			size_reg[REG_K_HEIGHT]  = 6'd3;
			size_reg[REG_K_WIDTH]   = 6'd3;
			size_reg[REG_STEP]      = 6'd1;
			size_reg[REG_PAD]       = 6'd0;
			expected_points.delete();
			pending_count = 0;
		end else begin
			if (cfg_we)
				size_reg[cfg_index] = cfg_data & CFG_W'((1 << reg_bits(cfg_index)) - 1);
			// response transaction against the oldest prediction
			if (rsp.valid && rsp.ready) begin
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected response, got value %0d status %0d", $time,
						rsp.conv_value, rsp.status);
					fail_count++;
				end else begin
					want = expected_points.pop_front();
					if (rsp.conv_value !== want.value || rsp.status !== want.status) begin
						$display("%0t: response mismatch, expected value %0d status %0d, got value %0d status %0d",
							$time, want.value, want.status, rsp.conv_value, rsp.status);
						fail_count++;
					end
				end
			end
			// command transaction, queued behind the older predictions
			if (cmd.valid && cmd.ready) begin
				want = predict_point(op_t'(cmd.opcode), int'(cmd.filter_index),
					int'(cmd.channel_index), int'(cmd.row_index), int'(cmd.col_index),
					cmd.load_value);
				expected_points = {expected_points, want};
			end
			pending_count = expected_points.size();
		end
	end

endmodule

// ----- bench/tb.sv -----
// top of the convolution point evaluator bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
	import c2pe_pkg::*;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [2:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int               fail_count;
	int               pending_count;

	c2pe_cmd_if cmd();
	c2pe_rsp_if rsp();

	// which store entries hold data, so that no query reads an unwritten one
	bit pixel_loaded  [PIX_DEPTH];
	bit weight_loaded [WGT_DEPTH];
	bit bias_loaded   [MAX_FILTERS];

	// sizes as the block uses them
	int eff_h, eff_w, eff_nc, eff_nf, eff_kh, eff_kw, eff_step, eff_pad;
	int burst_left;
	int items_sent;
	int wait_count;

	conv2d_point_evaluator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	conv_point_checker point_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rsp           (rsp),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always #6 clk = ~clk;

	function automatic int limit_size(input int v, input int hi);
		return (v == 0) ? 1 : ((v > hi) ? hi : v);
	endfunction

	function automatic int out_span(input int in_dim, input int kern);
		int span;
		span = in_dim + 2 * eff_pad - kern;
		if (span < 0)
			return 0;
		return span / eff_step + 1;
	endfunction

	// pixel or weight value: Q8.8 range in four of ten picks, else saturating extremes or raw words
	function automatic logic [LOAD_W-1:0] load_word();
		logic [15:0] half;
		half = 16'($urandom());
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_8000;
			3: return 32'hffff_7fff;
			4, 5: return $urandom();
			6: return {{16{half[15]}}, half} >>> 4;
			default: return {{16{half[15]}}, half};
		endcase
	endfunction

	// one command transaction, with bursts and gaps on the sender side
	task automatic issue(input op_t op, input int f, input int ch, input int r, input int c,
		input logic [LOAD_W-1:0] lv);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				cmd.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		cmd.valid         <= 1'b1;
		cmd.opcode        <= op;
		cmd.filter_index  <= 3'(f);
		cmd.channel_index <= 2'(ch);
		cmd.row_index     <= 5'(r);
		cmd.col_index     <= 5'(c);
		cmd.load_value    <= lv;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
		// note entries written by accepted loads
		case (op)
			OP_PIXEL:
				if (ch < eff_nc && r < eff_h && c < eff_w)
					pixel_loaded[(ch * MAX_DIM + r) * MAX_DIM + c] = 1'b1;
			OP_WEIGHT:
				if (f < eff_nf && ch < eff_nc && r < eff_kh && c < eff_kw)
					weight_loaded[((f * MAX_CHANNELS + ch) * MAX_KERNEL + r) * MAX_KERNEL + c] = 1'b1;
			OP_BIAS:
				if (f < eff_nf)
					bias_loaded[f] = 1'b1;
			default: ;
		endcase
	endtask

	// query one output point, first loading whatever it would read unwritten
	task automatic query_point(input int f, input int r, input int c);
		int z, a, b, pr, pc;
		if (f < eff_nf && r < out_span(eff_h, eff_kh) && c < out_span(eff_w, eff_kw)) begin
			for (z = 0; z < eff_nc; z++)
				for (a = 0; a < eff_kh; a++)
					for (b = 0; b < eff_kw; b++) begin
						pr = r * eff_step + a - eff_pad;
						pc = c * eff_step + b - eff_pad;
						if (pr >= 0 && pr < eff_h && pc >= 0 && pc < eff_w &&
							!pixel_loaded[(z * MAX_DIM + pr) * MAX_DIM + pc])
							issue(OP_PIXEL, $urandom_range(0, 7), z, pr, pc, load_word());
						if (!weight_loaded[((f * MAX_CHANNELS + z) * MAX_KERNEL + a) * MAX_KERNEL + b])
							issue(OP_WEIGHT, f, z, a, b, load_word());
					end
			if (!bias_loaded[f])
				issue(OP_BIAS, f, $urandom_range(0, 3), $urandom_range(0, 31),
					$urandom_range(0, 31), $urandom());
		end
		issue(OP_QUERY, f, $urandom_range(0, 3), r, c, $urandom());
	endtask

	// hold the sender until every response is back
	task automatic drain_results();
		cmd.valid <= 1'b0;
		burst_left = 0;
		do
			@(negedge clk);
		while (pending_count != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input int value);
		int bits;
		bits = (idx == REG_IN_HEIGHT || idx == REG_IN_WIDTH) ? 6 :
			((idx == REG_FILTERS || idx == REG_STEP) ? 4 : 3);
		// bits above the register width must be dropped by the block
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value | ($urandom_range(0, 63) << bits));
		@(negedge clk);
	endtask

	task automatic program_sizes(input int h, input int w, input int nc, input int nf,
		input int kh, input int kw, input int st, input int pd);
		write_reg(REG_IN_HEIGHT, h);
		write_reg(REG_IN_WIDTH, w);
		write_reg(REG_CHANNELS, nc);
		write_reg(REG_FILTERS, nf);
		write_reg(REG_K_HEIGHT, kh);
		write_reg(REG_K_WIDTH, kw);
		write_reg(REG_STEP, st);
		write_reg(REG_PAD, pd);
		cfg_we <= 1'b0;
		eff_h    = limit_size(h, MAX_DIM);
		eff_w    = limit_size(w, MAX_DIM);
		eff_nc   = limit_size(nc, MAX_CHANNELS);
		eff_nf   = limit_size(nf, MAX_FILTERS);
		eff_kh   = limit_size(kh, MAX_KERNEL);
		eff_kw   = limit_size(kw, MAX_KERNEL);
		eff_step = (st == 0) ? 1 : st;
		eff_pad  = pd;
	endtask

	// mostly well-formed loads and queries, some noise
	task automatic random_item();
		int pick, oh, ow;
		pick = $urandom_range(0, 99);
		oh = out_span(eff_h, eff_kh);
		ow = out_span(eff_w, eff_kw);
		if ($urandom_range(0, 59) == 0)
			drain_results();
		if (pick < 35) begin
			if (oh == 0 || ow == 0)
				query_point($urandom_range(0, eff_nf - 1), $urandom_range(0, 31),
					$urandom_range(0, 31));
			else
				query_point($urandom_range(0, eff_nf - 1), $urandom_range(0, (oh > 32 ? 32 : oh) - 1),
					$urandom_range(0, (ow > 32 ? 32 : ow) - 1));
		end else if (pick < 60) begin
			issue(OP_PIXEL, $urandom_range(0, 7), $urandom_range(0, eff_nc - 1),
				$urandom_range(0, eff_h - 1), $urandom_range(0, eff_w - 1), load_word());
		end else if (pick < 75) begin
			issue(OP_WEIGHT, $urandom_range(0, eff_nf - 1), $urandom_range(0, eff_nc - 1),
				$urandom_range(0, eff_kh - 1), $urandom_range(0, eff_kw - 1), load_word());
		end else if (pick < 82) begin
			issue(OP_BIAS, $urandom_range(0, eff_nf - 1), $urandom_range(0, 3),
				$urandom_range(0, 31), $urandom_range(0, 31), $urandom());
		end else if (pick < 90) begin
			query_point($urandom_range(0, 7), $urandom_range(0, 31), $urandom_range(0, 31));
		end else begin
			issue(op_t'($urandom_range(0, 2)), $urandom_range(0, 7), $urandom_range(0, 3),
				$urandom_range(0, 31), $urandom_range(0, 31), $urandom());
		end
	endtask

	task automatic run_phase(input int h, input int w, input int nc, input int nf,
		input int kh, input int kw, input int st, input int pd, input int count);
		int start;
		drain_results();
		program_sizes(h, w, nc, nf, kh, kw, st, pd);
		start = items_sent;
		while (items_sent - start < count)
			random_item();
	endtask

	// receiver stalls in stretches of its own pattern
	initial begin
		int mode, span, tick;
		rsp.ready = 1'b0;
		tick = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				tick++;
				case (mode)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= 1'($urandom_range(0, 1));
					2: rsp.ready <= ($urandom_range(0, 5) == 0);
					default: rsp.ready <= (tick % 4 == 0);
				endcase
			end
		end
	end

	// main stimulus
	initial begin
		arst_n            = 1'b0;
		cmd.valid         = 1'b0;
		cmd.opcode        = OP_PIXEL;
		cmd.filter_index  = '0;
		cmd.channel_index = '0;
		cmd.row_index     = '0;
		cmd.col_index     = '0;
		cmd.load_value    = '0;
		cfg_we            = 1'b0;
		cfg_index         = REG_IN_HEIGHT;
		cfg_data          = '0;
		burst_left        = 0;
		items_sent        = 0;
		eff_h = 32; eff_w = 32; eff_nc = 1; eff_nf = 1;
		eff_kh = 3; eff_kw = 3; eff_step = 1; eff_pad = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// sizes straight out of reset
		while (items_sent < 20)
			random_item();

		// directed: extremes, every operation, range errors, border queries
		drain_results();
		program_sizes(4, 5, 2, 2, 3, 2, 1, 1);
		issue(OP_PIXEL, 0, 0, 0, 0, 32'h7fff_ffff);
		issue(OP_PIXEL, 7, 1, 3, 4, 32'h8000_0000);
		issue(OP_PIXEL, 0, 0, 3, 4, 32'h0000_7fff);
		issue(OP_PIXEL, 0, 1, 0, 0, 32'hffff_8000);
		issue(OP_PIXEL, 0, 0, 1, 2, 32'h0000_8000);
		issue(OP_PIXEL, 0, 1, 1, 2, 32'hffff_7fff);
		issue(OP_WEIGHT, 1, 1, 2, 1, 32'h7fff_ffff);
		issue(OP_WEIGHT, 0, 0, 0, 0, 32'h8000_0000);
		issue(OP_BIAS, 1, 0, 0, 0, 32'h7fff_ffff);
		issue(OP_BIAS, 0, 0, 0, 0, 32'h8000_0000);
		issue(OP_PIXEL, 0, 2, 0, 0, 32'h0000_0100);
		issue(OP_PIXEL, 0, 0, 4, 0, 32'h0000_0100);
		issue(OP_PIXEL, 0, 0, 0, 5, 32'h0000_0100);
		issue(OP_PIXEL, 7, 3, 31, 31, 32'hffff_ffff);
		issue(OP_WEIGHT, 2, 0, 0, 0, 32'h0000_0100);
		issue(OP_WEIGHT, 0, 0, 3, 0, 32'h0000_0100);
		issue(OP_WEIGHT, 0, 0, 0, 2, 32'h0000_0100);
		issue(OP_BIAS, 7, 3, 31, 31, 32'h0000_0000);
		issue(OP_QUERY, 2, 0, 0, 0, 32'h0);
		issue(OP_QUERY, 0, 0, 4, 0, 32'h0);
		issue(OP_QUERY, 0, 0, 0, 6, 32'h0);
		query_point(0, 0, 0);
		query_point(1, 3, 5);
		query_point(1, 31, 31);
		query_point(0, 1, 2);

		// fixed corners of the size space
		run_phase(1, 1, 1, 1, 1, 1, 1, 0, 30);
		run_phase(32, 32, 4, 8, 5, 5, 8, 4, 40);
		run_phase(3, 2, 4, 8, 5, 5, 15, 7, 20);
		// padded input smaller than the kernel: every query is out of range
		run_phase(2, 2, 1, 3, 5, 4, 2, 0, 25);
		// register values outside their limits
		run_phase(63, 0, 7, 0, 0, 7, 0, 3, 40);

		// random sizes, mostly small maps
		repeat (4)
			run_phase(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 10),
				($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 10),
				$urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 7),
				$urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 7), 20);

		// wait for the last responses
		cmd.valid <= 1'b0;
		wait_count = 0;
		while (pending_count != 0 && wait_count < 50000) begin
			@(negedge clk);
			wait_count++;
		end
		repeat (120) @(negedge clk);
		if (pending_count != 0)
			$display("%0t: %0d expected responses never arrived", $time, pending_count);
		if (fail_count == 0 && pending_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// run limit
	initial begin
		#12_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
